@@ sv/tea_pkg.sv @@
// Package for the TEA block cipher unit.
// Holds the payload structs, key bundle, register codes and round constants.
// No dependencies.
package tea_pkg;

  // Cipher constants.
  localparam int unsigned TEA_ROUNDS  = 32;
  localparam logic [31:0] TEA_DELTA   = 32'h9E37_79B9;
  localparam int unsigned CFG_IDX_W   = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD0 = 3'd0,
    CFG_KEY_WORD1 = 3'd1,
    CFG_KEY_WORD2 = 3'd2,
    CFG_KEY_WORD3 = 3'd3,
    CFG_DIRECTION = 3'd4
  } cfg_reg_e;

  // One input word: the two halves of a 64-bit block.
  typedef struct packed {
    logic [31:0] first_word;
    logic [31:0] second_word;
  } in_word_t;

  // One output word: the two halves of the processed block.
  typedef struct packed {
    logic [31:0] first_result;
    logic [31:0] second_result;
  } out_word_t;

  // The 128-bit key as four 32-bit words.
  typedef struct packed {
    logic [31:0] key_word0;
    logic [31:0] key_word1;
    logic [31:0] key_word2;
    logic [31:0] key_word3;
  } key_t;

  // Running sum after n additions of delta, modulo 2^32.
  function automatic logic [31:0] round_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(n);
    return prod[31:0];
  endfunction

endpackage

@@ sv/tea_cfg_regs.sv @@
// Configuration register file of the TEA block cipher unit.
// Holds the four key words and the direction bit; uses tea_pkg.
module tea_cfg_regs import tea_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output key_t                 key_o,
  output logic                 dir_o
);

  key_t key_q, key_d;
  logic dir_q, dir_d;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    key_d = key_q;
    dir_d = dir_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_KEY_WORD0: key_d.key_word0 = cfg_data_i;
        CFG_KEY_WORD1: key_d.key_word1 = cfg_data_i;
        CFG_KEY_WORD2: key_d.key_word2 = cfg_data_i;
        CFG_KEY_WORD3: key_d.key_word3 = cfg_data_i;
        CFG_DIRECTION: dir_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      dir_q <= 1'b0;
    end else begin
      key_q <= key_d;
      dir_q <= dir_d;
    end
  end

  assign key_o = key_q;
  assign dir_o = dir_q;

endmodule

@@ sv/tea_half_round.sv @@
// One pipeline stage of the TEA cipher: a single half-round update.
// Updates one half of the block from the other; uses tea_pkg.
module tea_half_round import tea_pkg::*; #(
  parameter logic [31:0] ENC_SUM   = TEA_DELTA,
  parameter logic [31:0] DEC_SUM   = TEA_DELTA,
  parameter bit          UPD_A_ENC = 1'b1
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     dir_i,
  input  key_t     key_i,
  input  logic     valid_i,
  input  in_word_t blk_i,
  output logic     valid_o,
  output in_word_t blk_o
);

  logic        upd_a;
  logic [31:0] src, dst, sum, ka, kb, mix, res;
  logic        valid_q;
  in_word_t    blk_q, blk_d;

  // Decryption walks the half-rounds backwards, so the updated half flips.
  assign upd_a = UPD_A_ENC ^ dir_i;
  assign sum   = dir_i ? DEC_SUM : ENC_SUM;
  assign src   = upd_a ? blk_i.second_word : blk_i.first_word;
  assign dst   = upd_a ? blk_i.first_word  : blk_i.second_word;
  assign ka    = upd_a ? key_i.key_word0   : key_i.key_word2;
  assign kb    = upd_a ? key_i.key_word1   : key_i.key_word3;

  // Mixing term, then add for encryption or subtract for decryption.
  assign mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
  assign res = dir_i ? (dst - mix) : (dst + mix);

  always_comb begin
    blk_d = blk_i;
    if (upd_a) begin
      blk_d.first_word = res;
    end else begin
      blk_d.second_word = res;
    end
  end

  // Valid bit is control state; the data register needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

@@ sv/tea_block_cipher_unit.sv @@
// Top level of the TEA block cipher unit.
// Instantiates tea_cfg_regs and one tea_half_round per pipeline stage; uses tea_pkg.

// The unit enciphers or deciphers one 64-bit block per word under a 128-bit key
// held in four configuration registers, with the direction register choosing
// the operation. Every half-round is a register stage, so the pipeline is
// 2*ROUNDS stages deep (64 at the default of 32 rounds), and a new word can be
// taken in every cycle while the pipeline is not held. The whole pipeline holds
// while a finished result waits at the output and the output is stalled; bubbles
// inside are not squeezed out while it holds. Key and direction are read live by
// every stage, so they must only be written while no word is in flight.
module tea_block_cipher_unit import tea_pkg::*; #(
  parameter int unsigned ROUNDS = TEA_ROUNDS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned STAGES = 2 * ROUNDS;

  key_t     key;
  logic     dir;
  logic     adv;
  logic     stage_vld [STAGES+1];
  in_word_t stage_blk [STAGES+1];

  // Configuration registers.
  tea_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key),
    .dir_o       (dir)
  );

  // The pipeline moves unless a finished word is held at the output.
  assign adv        = !(stage_vld[STAGES] && out_stall_i);
  assign in_stall_o = !adv;

  assign stage_vld[0] = in_valid_i;
  assign stage_blk[0] = in_word_i;

  // Half-round stages; stage s belongs to round s/2.
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int unsigned RND = s / 2;
    tea_half_round #(
      .ENC_SUM   (round_sum(RND + 1)),
      .DEC_SUM   (round_sum(ROUNDS - RND)),
      .UPD_A_ENC ((s % 2) == 0)
    ) u_half_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .dir_i   (dir),
      .key_i   (key),
      .valid_i (stage_vld[s]),
      .blk_i   (stage_blk[s]),
      .valid_o (stage_vld[s+1]),
      .blk_o   (stage_blk[s+1])
    );
  end

  // The last stage register is the output register.
  assign out_valid_o              = stage_vld[STAGES];
  assign out_word_o.first_result  = stage_blk[STAGES].first_word;
  assign out_word_o.second_result = stage_blk[STAGES].second_word;

endmodule

@@ tb/tea_block_cipher_unit_test.sv @@
// Self-checking testbench for the TEA block cipher unit, tea_block_cipher_unit.
// Predicts every output word with a built-in 32-round TEA cipher under the current
// key and direction; depends on tea_pkg and the unit's RTL only.
module tea_block_cipher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tea_pkg::*;

  localparam int unsigned PIPE_DEPTH       = 2 * TEA_ROUNDS;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned RANDOM_PER_PHASE = 165;

  typedef enum {RX_READY, RX_RANDOM, RX_BURSTY} rx_pattern_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_word_t             in_word_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_word_t            out_word_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  // Predictor copy of the key and direction registers.
  key_t model_key;
  logic model_decrypt;

  // Cipher results still owed by the unit, oldest first.
  out_word_t pending_blocks[$];

  int unsigned err_count      = 0;
  int unsigned blocks_sent    = 0;
  int unsigned blocks_checked = 0;
  int unsigned settings_used  = 0;

  // Receiver control, shared with the stall process.
  rx_pattern_e rx_pattern = RX_READY;
  int unsigned hold_len   = 0;
  int unsigned hold_seq   = 0;

  // Boundary data blocks used by the directed tests.
  in_word_t corner_blocks[4] = '{
    {32'h0000_0000, 32'h0000_0000},
    {32'hFFFF_FFFF, 32'hFFFF_FFFF},
    {32'hAAAA_AAAA, 32'h5555_5555},
    {32'h8000_0000, 32'h0000_0001}
  };

  tea_block_cipher_unit u_top (.*);

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mixing term of one half-round.
  function automatic logic [31:0] feistel_mix(logic [31:0] w, logic [31:0] sum,
                                              logic [31:0] ka, logic [31:0] kb);
    return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
  endfunction

  // Full TEA encryption or decryption of one block under the predictor's registers.
  function automatic out_word_t tea_cipher_block(in_word_t blk);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sum;
    out_word_t   res;
    a   = blk.first_word;
    b   = blk.second_word;
    sum = '0;
    if (!model_decrypt) begin
      for (int r = 0; r < TEA_ROUNDS; r++) begin
        sum += TEA_DELTA;
        a += feistel_mix(b, sum, model_key.key_word0, model_key.key_word1);
        b += feistel_mix(a, sum, model_key.key_word2, model_key.key_word3);
      end
    end else begin
      // Decryption starts from the sum reached after the last round.
      for (int r = 0; r < TEA_ROUNDS; r++) sum += TEA_DELTA;
      for (int r = 0; r < TEA_ROUNDS; r++) begin
        b -= feistel_mix(a, sum, model_key.key_word2, model_key.key_word3);
        a -= feistel_mix(b, sum, model_key.key_word0, model_key.key_word1);
        sum -= TEA_DELTA;
      end
    end
    res.first_result  = a;
    res.second_result = b;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 30) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Offers one word and holds it until the unit takes it; returns at a falling edge
  // with valid still high so that back-to-back words go without a gap.
  task automatic send_block(in_word_t blk);
    in_valid_i = 1'b1;
    in_word_i  = blk;
    do @(posedge clk_i); while (in_stall_o);
    pending_blocks.push_back(tea_cipher_block(blk));
    blocks_sent++;
    @(negedge clk_i);
  endtask

  // Sender gap with junk on the data lines.
  task automatic idle_sender(int unsigned cycles);
    in_valid_i = 1'b0;
    repeat (cycles) begin
      in_word_i = {$urandom, $urandom};
      @(negedge clk_i);
    end
  endtask

  // Stops sending until every owed result has come back.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One register write; the predictor follows the same decode as the unit.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_KEY_WORD0: model_key.key_word0 = data;
      CFG_KEY_WORD1: model_key.key_word1 = data;
      CFG_KEY_WORD2: model_key.key_word2 = data;
      CFG_KEY_WORD3: model_key.key_word3 = data;
      CFG_DIRECTION: model_decrypt = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Loads a full key and direction; the upper direction bits carry noise.
  task automatic set_config(key_t k, logic decrypt);
    logic [31:0] dir_data;
    dir_data    = $urandom;
    dir_data[0] = decrypt;
    write_reg(CFG_KEY_WORD0, k.key_word0);
    write_reg(CFG_KEY_WORD1, k.key_word1);
    write_reg(CFG_KEY_WORD2, k.key_word2);
    write_reg(CFG_KEY_WORD3, k.key_word3);
    write_reg(CFG_DIRECTION, dir_data);
    settings_used++;
  endtask

  // Random blocks in bursts, with optional random gaps between the bursts.
  task automatic run_random_blocks(int unsigned count, rx_pattern_e pat, bit gaps);
    int unsigned sent;
    int unsigned burst;
    sent       = 0;
    rx_pattern = pat;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_block({$urandom, $urandom});
        sent++;
      end
      if (gaps && $urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  // After reset the key is all zeros and the unit encrypts.
  task automatic test_reset_state();
    foreach (corner_blocks[i]) send_block(corner_blocks[i]);
    wait_idle();
  endtask

  // Extreme keys in both directions on the boundary blocks.
  task automatic test_directed_extremes();
    set_config('1, 1'b0);
    foreach (corner_blocks[i]) send_block(corner_blocks[i]);
    wait_idle();
    set_config('1, 1'b1);
    foreach (corner_blocks[i]) send_block(corner_blocks[i]);
    wait_idle();
    set_config({32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1);
    foreach (corner_blocks[i]) send_block(corner_blocks[i]);
    wait_idle();
  endtask

  // Indexes past the direction register are ignored, and only bit 0 of the
  // direction data counts.
  task automatic test_register_writes();
    set_config({$urandom, $urandom, $urandom, $urandom}, 1'b1);
    for (int i = int'(CFG_DIRECTION) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), $urandom);
    end
    send_block({$urandom, $urandom});
    send_block({$urandom, $urandom});
    wait_idle();
    write_reg(CFG_DIRECTION, 32'hFFFF_FFFE);
    send_block({$urandom, $urandom});
    wait_idle();
    write_reg(CFG_DIRECTION, 32'h0000_0001);
    send_block({$urandom, $urandom});
    wait_idle();
  endtask

  // Random blocks under a series of keys, alternating direction, with varied
  // sender gaps and receiver stall patterns; one phase runs at full rate.
  task automatic test_random_phases();
    key_t phase_key;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: phase_key = '0;
        1: phase_key = '1;
        default: phase_key = {$urandom, $urandom, $urandom, $urandom};
      endcase
      wait_idle();
      set_config(phase_key, p[0]);
      run_random_blocks(RANDOM_PER_PHASE, rx_pattern_e'(p % 3), p != 3);
    end
    wait_idle();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall its
  // input while the sender keeps offering words.
  task automatic test_backpressure();
    set_config({$urandom, $urandom, $urandom, $urandom}, 1'($urandom));
    rx_pattern = RX_RANDOM;
    hold_len   = 4 * PIPE_DEPTH;
    hold_seq++;
    for (int k = 0; k < 3 * PIPE_DEPTH; k++) send_block({$urandom, $urandom});
    wait_idle();
  endtask

  // Receiver stall process: a long hold-off when asked, else the current pattern.
  initial begin : rx_stall_gen
    int unsigned hold_left;
    int unsigned seen_seq;
    int unsigned run_left;
    hold_left   = 0;
    seen_seq    = 0;
    run_left    = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        case (rx_pattern)
          RX_READY: out_stall_i = 1'b0;
          RX_RANDOM: out_stall_i = ($urandom_range(0, 99) < 35);
          RX_BURSTY: begin
            if (run_left == 0) begin
              out_stall_i = ~out_stall_i;
              run_left    = $urandom_range(1, 12);
            end
            run_left--;
          end
          default: out_stall_i = 1'b0;
        endcase
      end
    end
  end

  // Compares each accepted output word with the oldest owed result.
  always @(posedge clk_i) begin : result_check
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch($sformatf("output word %h with no block pending", out_word_o));
      end else begin
        want = pending_blocks.pop_front();
        blocks_checked++;
        if (out_word_o.first_result !== want.first_result) begin
          report_mismatch($sformatf("first_result %h, expected %h",
                                    out_word_o.first_result, want.first_result));
        end
        if (out_word_o.second_result !== want.second_result) begin
          report_mismatch($sformatf("second_result %h, expected %h",
                                    out_word_o.second_result, want.second_result));
        end
      end
    end
  end

  // Test sequence.
  initial begin : stimulus
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    model_key     = '0;
    model_decrypt = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_directed_extremes();
    test_register_writes();
    test_random_phases();
    test_backpressure();

    wait_idle();
    repeat (PIPE_DEPTH + 8) @(negedge clk_i);
    $display("Checked %0d of %0d cipher blocks over %0d key and direction settings.",
             blocks_checked, blocks_sent, settings_used);
    $display("Covered both directions, extreme keys and blocks, %s",
             "ignored indexes and a long hold-off.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout: the unit stopped moving words");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
sv/tea_pkg.sv
sv/tea_cfg_regs.sv
sv/tea_half_round.sv
sv/tea_block_cipher_unit.sv
tb/tea_block_cipher_unit_test.sv
